// ===== rtl/core/sha256_message_hasher_assert.svh =====
// Assertion macros for the SHA-256 message hasher.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Constants, round function helpers and sequencer state type.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned CountW = 61;
    localparam int unsigned Rounds = 64;

    typedef logic [WordW-1:0] t_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FINAL,
        S_PAD,
        S_EMIT
    } t_state;

    function automatic t_word iv_word(input logic [2:0] idx);
        t_word r;
        unique case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    localparam t_word RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage

// ===== rtl/core/sha256_message_hasher.sv =====
`timescale 1ns / 1ps
// A byte that does not fill a block is taken while idle; a 64th byte
//   starts compression: 64 rounds in the one shared round unit, then a fold.
// A message end takes one or two block compressions, then 8 output items.
// Bytes are accepted only while idle, not during compression or digest output.
// Reset: i_rst_n synchronous active low; chain value to IV, count to zero.
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-serial front end, one round per cycle compression, digest output.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [8] byte_valid, [15:9] zero
    input  logic        s_axis_tlast,  // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] digest_word
    output logic        m_axis_tlast   // digest_last
);
    import sha256_pkg::*;
    `include "sha256_message_hasher_assert.svh"

    t_state r_state, n_state;
    t_word  r_h [8];          // chaining value
    t_word  r_v [8];          // working variables
    t_word  r_w [16];         // block words, then schedule window
    logic [CountW-1:0] r_cnt;
    logic [5:0] r_rnd;
    logic [2:0] r_oidx;
    logic       r_end;        // message end pending after current block
    logic       r_pad2;       // second padding block still needed
    logic       r_padded;     // padding of the ending message has begun
    t_word  rv_n [8];
    t_word  rw_n [16];

    logic acc, ins;
    logic [5:0] pos;

    sha256_round u_round (
        .i_v(r_v), .i_w(r_w), .i_round(r_rnd), .o_v(rv_n), .o_w(rw_n)
    );

    assign acc = s_axis_tvalid && s_axis_tready;
    assign ins = s_axis_tdata[8];
    assign pos = r_cnt[5:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (ins && pos == 6'd63) n_state = S_ROUND;
                    else if (s_axis_tlast) n_state = S_PAD;
                end
            end
            S_ROUND: if (r_rnd == 6'd63) n_state = S_FINAL;
            S_FINAL: begin
                // a block filled by the ending byte still needs its padding block
                if (r_pad2) n_state = S_PAD;
                else if (r_end) n_state = r_padded ? S_EMIT : S_PAD;
                else n_state = S_IDLE;
            end
            S_PAD:  n_state = S_ROUND;
            S_EMIT: if (m_axis_tready && r_oidx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_EMIT);
        m_axis_tdata  = r_h[r_oidx];
        m_axis_tlast  = (r_oidx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_rnd    <= '0;
            r_oidx   <= '0;
            r_end    <= 1'b0;
            r_pad2   <= 1'b0;
            r_padded <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= iv_word(3'(i));
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (ins) begin
                            r_w[pos[5:2]][8*(3-pos[1:0]) +: 8] <= s_axis_tdata[7:0];
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_end    <= s_axis_tlast;
                        r_pad2   <= 1'b0;
                        r_padded <= 1'b0;
                        r_rnd    <= '0;
                        r_v      <= r_h;
                    end
                end
                S_ROUND: begin
                    r_v   <= rv_n;
                    r_w   <= rw_n;
                    r_rnd <= r_rnd + 1'b1;
                end
                S_FINAL: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oidx <= '0;
                end
                S_PAD: begin
                    // pad the open block (first) or build a zero block with the length (second)
                    if (!r_pad2) begin
                        for (int i = 0; i < 16; i++) begin
                            for (int b = 0; b < 4; b++) begin
                                if (6'(4*i+b) == pos)
                                    r_w[i][8*(3-b) +: 8] <= 8'h80;
                                else if (6'(4*i+b) > pos)
                                    r_w[i][8*(3-b) +: 8] <= 8'h00;
                            end
                        end
                        if (pos >= 6'd56) r_pad2 <= 1'b1;
                        else begin
                            r_w[14] <= {r_cnt[CountW-1:29]};
                            r_w[15] <= {r_cnt[28:0], 3'b000};
                        end
                    end else begin
                        for (int i = 0; i < 14; i++) r_w[i] <= '0;
                        r_w[14] <= {r_cnt[CountW-1:29]};
                        r_w[15] <= {r_cnt[28:0], 3'b000};
                        r_pad2  <= 1'b0;
                    end
                    r_padded <= 1'b1;
                    r_v      <= r_h;
                    r_rnd    <= '0;
                end
                S_EMIT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= iv_word(3'(i));
                            r_cnt <= '0;
                            r_end <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `SHA_ASSERT_IMP(a_no_acc_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready,
        "ready while busy")
    `SHA_ASSERT_NXT(a_round_adv, i_clk, i_rst_n, r_state == S_ROUND && r_rnd != 6'd63,
        r_state == S_ROUND, "round sequence broken")
    `SHA_ASSERT_IMP(a_emit_end, i_clk, i_rst_n, r_state == S_EMIT, r_end,
        "digest without message end")
    `SHA_ASSERT_NXT(a_last_done, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && m_axis_tlast,
        r_state == S_IDLE && r_cnt == '0, "no restart after digest")

endmodule

// ===== rtl/core/sha256_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round plus one message schedule step per cycle over a
// sliding 16-word window.
// ----------------------------------------------------------------------------
module sha256_round (
    input  sha256_pkg::t_word i_v [8],
    input  sha256_pkg::t_word i_w [16],
    input  logic [5:0]        i_round,
    output sha256_pkg::t_word o_v [8],
    output sha256_pkg::t_word o_w [16]
);
    import sha256_pkg::*;

    t_word t1, t2, s0, s1, wn;

    always_comb begin
        t1 = i_v[7] + (rotr(i_v[4], 6) ^ rotr(i_v[4], 11) ^ rotr(i_v[4], 25))
           + ((i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6])) + RoundK[i_round] + i_w[0];
        t2 = (rotr(i_v[0], 2) ^ rotr(i_v[0], 13) ^ rotr(i_v[0], 22))
           + ((i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]));
        o_v[0] = t1 + t2;
        o_v[1] = i_v[0];
        o_v[2] = i_v[1];
        o_v[3] = i_v[2];
        o_v[4] = i_v[3] + t1;
        o_v[5] = i_v[4];
        o_v[6] = i_v[5];
        o_v[7] = i_v[6];
        // next schedule word w[t+16]
        s0 = rotr(i_w[1], 7) ^ rotr(i_w[1], 18) ^ (i_w[1] >> 3);
        s1 = rotr(i_w[14], 17) ^ rotr(i_w[14], 19) ^ (i_w[14] >> 10);
        wn = s1 + i_w[9] + s0 + i_w[0];
        for (int i = 0; i < 15; i++) o_w[i] = i_w[i+1];
        o_w[15] = wn;
    end
endmodule
